/* sv/dual_stack_shared_memory_top_defines.svh */
// assertion macros shared by the two-stack block
// expects i_clk and i_rst_n in the module that uses them
`ifndef DUAL_STACK_SHARED_MEMORY_TOP_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_TOP_DEFINES_SVH

// condition holds at every clock edge outside reset
`define DSSM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DSSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define DSSM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/dssm_pkg.sv */
// types and codes for the two-stack shared memory block
// used by dssm_ctrl, dssm_dp and the top level; depends on nothing
package dssm_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] SIZE_RESET = 7'd32;

    // request commands
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_LIST = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // configuration register indexes
    localparam logic CFG_FIRST_SIZE  = 1'b0;
    localparam logic CFG_SECOND_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]               command;
        logic                     which_stack;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
        logic                     last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       push_wr;
        logic       pop_rd;
        logic       list_rd;
        logic       emit;
        logic [1:0] emit_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       empty;
        logic       full;
        logic       list_last;
    } t_dp_stat;

endpackage

/* sv/dssm_ctrl.sv */
// request sequencer for the two-stack block
// depends on dssm_pkg; drives dssm_dp through t_dp_cmd
module dssm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  dssm_pkg::t_dp_stat i_stat,
    output dssm_pkg::t_dp_cmd  o_cmd
);
    import dssm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.command)
                    CMD_PUSH: begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.emit_status = ST_OVER;
                        end else begin
                            o_cmd.push_wr     = 1'b1;
                            o_cmd.emit_status = ST_OK;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_UNDER;
                        end else begin
                            o_cmd.pop_rd = 1'b1;
                        end
                    end
                    CMD_LIST: begin
                        if (i_stat.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_EMPTY;
                        end else begin
                            o_cmd.list_rd = 1'b1;
                            if (!i_stat.list_last) begin
                                n_state = S_LIST;
                            end
                        end
                    end
                    // unused command code gives no result
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LIST: begin
                o_cmd.list_rd = 1'b1;
                if (i_stat.list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

/* sv/dssm_dp.sv */
// datapath of the two-stack block: size registers, counts, word memory, result register
// depends on dssm_pkg and the assertion macros header
`include "dual_stack_shared_memory_top_defines.svh"

module dssm_dp #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dssm_pkg::t_in_item            i_item,
    input  dssm_pkg::t_dp_cmd             i_cmd,
    output dssm_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [dssm_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                          o_strobe,
    output dssm_pkg::t_out_item           o_result
);
    import dssm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic [CNT_W-1:0]  r_first, r_second;
    logic [CNT_W-1:0]  r_cnt1, r_cnt2;
    logic [CNT_W-1:0]  r_idx;
    logic [1:0]        r_command;
    logic              r_which;
    logic [DATA_W-1:0] r_push_value;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_rd_vld;
    logic              r_rd_last;

    logic              r_strobe;
    t_out_item         r_out;

    logic [CNT_W-1:0]  base2, room, cap2;
    logic [CNT_W-1:0]  cnt, cap, base;
    logic [CNT_W-1:0]  wr_full, rd_full;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic              list_last;

    // stack two starts where stack one ends, both clipped to the memory
    assign base2 = (r_first > DEPTH_C) ? DEPTH_C : r_first;
    assign room  = DEPTH_C - base2;
    assign cap2  = (r_second > room) ? room : r_second;

    assign cnt  = r_which ? r_cnt2 : r_cnt1;
    assign cap  = r_which ? cap2 : base2;
    assign base = r_which ? base2 : '0;

    assign wr_full = base + cnt;
    assign rd_full = i_cmd.pop_rd ? (base + cnt - CNT_W'(1)) : (base + r_idx);
    assign wr_addr = wr_full[AW-1:0];
    assign rd_addr = rd_full[AW-1:0];

    assign list_last = ((r_idx + CNT_W'(1)) == cnt);

    assign o_stat.command   = r_command;
    assign o_stat.empty     = (cnt == '0);
    assign o_stat.full      = (cnt >= cap);
    assign o_stat.list_last = list_last;

    // latched request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command    <= i_item.command;
            r_which      <= i_item.which_stack;
            r_push_value <= i_item.push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= SIZE_RESET;
            r_second <= SIZE_RESET;
            r_cnt1   <= '0;
            r_cnt2   <= '0;
            r_idx    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIRST_SIZE:  r_first  <= i_cfg_data;
                    CFG_SECOND_SIZE: r_second <= i_cfg_data;
                    default:         r_first  <= r_first;
                endcase
                // new split empties both stacks
                r_cnt1 <= '0;
                r_cnt2 <= '0;
            end else if (i_cmd.push_wr) begin
                if (r_which) begin
                    r_cnt2 <= r_cnt2 + CNT_W'(1);
                end else begin
                    r_cnt1 <= r_cnt1 + CNT_W'(1);
                end
            end else if (i_cmd.pop_rd) begin
                if (r_which) begin
                    r_cnt2 <= r_cnt2 - CNT_W'(1);
                end else begin
                    r_cnt1 <= r_cnt1 - CNT_W'(1);
                end
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.list_rd) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // word memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[wr_addr] <= r_push_value;
        end
        if (i_cmd.pop_rd || i_cmd.list_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.pop_rd || i_cmd.list_rd;
            r_strobe <= r_rd_vld || i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= i_cmd.pop_rd || list_last;
        if (r_rd_vld) begin
            r_out.value  <= r_rdata;
            r_out.status <= ST_OK;
            r_out.last   <= r_rd_last;
        end else begin
            r_out.value  <= '0;
            r_out.status <= i_cmd.emit_status;
            r_out.last   <= 1'b1;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `DSSM_ASSERT_ALWAYS(a_cnt1_fits, r_cnt1 <= base2, "stack one count beyond its capacity")
    `DSSM_ASSERT_ALWAYS(a_cnt2_fits, r_cnt2 <= cap2, "stack two count beyond its capacity")
    `DSSM_ASSERT_ALWAYS(a_no_clash, !(r_rd_vld && i_cmd.emit), "read word and status result collide")
    `DSSM_ASSERT_SAME(a_push_room, i_cmd.push_wr, cnt < cap, "push written into a full stack")
    `DSSM_ASSERT_NEXT(a_read_out, r_rd_vld, o_strobe && (o_result.status == ST_OK), "read word not delivered")

endmodule

/* sv/dual_stack_shared_memory_top.sv */
// two LIFO stacks in one shared word memory: controller plus datapath
// depends on dssm_pkg, dssm_ctrl and dssm_dp
//
// A request (push, pop or list on stack one or two) is taken on a clock edge
// where i_start is high and o_busy is low. Each result appears for one cycle
// on o_result with o_strobe high; the receiver takes every result as it comes.
// Configuration (stack one capacity at index 0, stack two capacity at index 1)
// is written through i_cfg_we / i_cfg_index / i_cfg_data while no request is
// in flight; any write empties both stacks.
// Order of events after the accepting edge:
//   push, failed pop, empty list: the status result goes straight into the
//   output register
//   pop: one memory read; the word passes the read register, then the output register
//   push and pop are busy for one cycle; no request is taken while busy
//   list of n words: busy while its words are read, one word per cycle, each
//   word passing the read register and then the output register, last flagged
//   on the top word; the next request is taken once busy drops
// Reset clears both counts and sets both capacities to 32; memory contents are
// left as they are, since an entry is only read after a push wrote it.
module dual_stack_shared_memory_top #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  dssm_pkg::t_in_item         i_item,
    output logic                       o_strobe,
    output dssm_pkg::t_out_item        o_result,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [dssm_pkg::CNT_W-1:0] i_cfg_data
);
    import dssm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dssm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
